FILE: sv/button_click_long_press_classifier_unit_defines.svh
// Assertion macros for the button click / long-press classifier.
// Used by the top level; depends on nothing else.
`ifndef BUTTON_CLICK_LONG_PRESS_CLASSIFIER_UNIT_DEFINES_SVH
`define BUTTON_CLICK_LONG_PRESS_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BCLPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BCLPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bclpc_pkg.sv
// Shared types and codes for the button click / long-press classifier.
// No dependencies.
`timescale 1ns / 1ps

package bclpc_pkg;

    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned EVENT_W = 3;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned NUM_BTN = 3;

    localparam logic [COUNT_W-1:0] LONG_PRESS_RESET = 16'd60;
    localparam logic [COUNT_W-1:0] HOLD_MAX         = 16'hFFFF;

    // Item kinds
    localparam logic [FUNC_W-1:0] FUNC_PIN_CHANGE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK       = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ       = 2'd2;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
    localparam logic [EVENT_W-1:0] EV_B1_CLICK = 3'd1;
    localparam logic [EVENT_W-1:0] EV_B2_CLICK = 3'd2;
    localparam logic [EVENT_W-1:0] EV_B3_CLICK = 3'd3;
    localparam logic [EVENT_W-1:0] EV_B1_LONG  = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [NUM_BTN-1:0] levels;   // bit 0 = button one, 0 means pressed
    } t_item;

    typedef struct packed {
        logic               sampling_active;
        logic [EVENT_W-1:0] pending_code;
        logic [EVENT_W-1:0] event_code;
    } t_result;

endpackage

FILE: sv/bclpc_core.sv
// Classifier state and next-state logic: press set, hold counter, long flag,
// pending event, timer flag and the long-press limit. Depends on bclpc_pkg.
`timescale 1ns / 1ps

module bclpc_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bclpc_pkg::COUNT_W-1:0]     i_cfg_wdata,
    input  logic                              i_step,
    input  bclpc_pkg::t_item                  i_item,
    output bclpc_pkg::t_result                o_res
);

    logic [bclpc_pkg::COUNT_W-1:0] r_long_ticks;
    logic [bclpc_pkg::NUM_BTN-1:0] r_pressed, n_pressed;
    logic [bclpc_pkg::COUNT_W-1:0] r_hold, n_hold;
    logic                          r_long_seen, n_long_seen;
    logic [bclpc_pkg::EVENT_W-1:0] r_pending, n_pending;
    logic                          r_running, n_running;
    logic [bclpc_pkg::EVENT_W-1:0] ev;
    logic [bclpc_pkg::NUM_BTN-1:0] now;
    logic [bclpc_pkg::COUNT_W-1:0] hold_inc;

    assign now      = ~i_item.levels;
    assign hold_inc = (r_hold == bclpc_pkg::HOLD_MAX) ? r_hold
                                                      : r_hold + bclpc_pkg::COUNT_W'(1);

    always_comb begin
        n_pressed   = r_pressed;
        n_hold      = r_hold;
        n_long_seen = r_long_seen;
        n_pending   = r_pending;
        n_running   = r_running;
        ev          = bclpc_pkg::EV_NONE;
        case (i_item.func)
            bclpc_pkg::FUNC_PIN_CHANGE: begin
                n_running = 1'b1;
            end
            bclpc_pkg::FUNC_TICK: begin
                if (r_running) begin
                    if (now != '0) begin
                        n_pressed = now;
                        n_hold    = hold_inc;
                        if (now[0] && (hold_inc > r_long_ticks) && !r_long_seen) begin
                            n_long_seen = 1'b1;
                            n_pending   = bclpc_pkg::EV_B1_LONG;
                        end
                    end else begin
                        // all released: a single-button press becomes a click, except button one after a long press
                        if (r_pressed == 3'b001 && !r_long_seen) begin
                            n_pending = bclpc_pkg::EV_B1_CLICK;
                        end else if (r_pressed == 3'b010) begin
                            n_pending = bclpc_pkg::EV_B2_CLICK;
                        end else if (r_pressed == 3'b100) begin
                            n_pending = bclpc_pkg::EV_B3_CLICK;
                        end
                        n_pressed   = '0;
                        n_hold      = '0;
                        n_long_seen = 1'b0;
                        n_running   = 1'b0;
                    end
                end
            end
            bclpc_pkg::FUNC_READ: begin
                ev        = r_pending;
                n_pending = bclpc_pkg::EV_NONE;
            end
            default: begin
            end
        endcase
    end

    assign o_res.event_code      = ev;
    assign o_res.pending_code    = n_pending;
    assign o_res.sampling_active = n_running;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks <= bclpc_pkg::LONG_PRESS_RESET;
            r_pressed    <= '0;
            r_hold       <= '0;
            r_long_seen  <= 1'b0;
            r_pending    <= bclpc_pkg::EV_NONE;
            r_running    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_long_ticks <= i_cfg_wdata;
            end
            if (i_step) begin
                r_pressed   <= n_pressed;
                r_hold      <= n_hold;
                r_long_seen <= n_long_seen;
                r_pending   <= n_pending;
                r_running   <= n_running;
            end
        end
    end

endmodule

FILE: sv/button_click_long_press_classifier_unit.sv
// Top level of the button click / long-press classifier: input register,
// result register and stream handshakes. Depends on bclpc_pkg, bclpc_core
// and button_click_long_press_classifier_unit_defines.svh.
//
//   channel   | dir | handshake                | payload
//   ----------+-----+--------------------------+---------------------------------
//   s_axis    | in  | tvalid / tready          | tdata: levels, tuser: func
//   m_axis    | out | tvalid / tready          | tdata: event, pending, active
//   cfg       | in  | write enable, no wait    | long_press_ticks
//
// One word per cycle while the output is not stalled; an accepted word passes
// through the input register, then the result register.
// The state update is combinational between the two registers.
// A stalled output holds its word; the input register still takes one more.
// Synchronous active-low reset empties both registers and resets all state.
`timescale 1ns / 1ps
`include "button_click_long_press_classifier_unit_defines.svh"

module button_click_long_press_classifier_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,      // long_press_ticks
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [0] level_one, [1] level_two, [2] level_three
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata    // [2:0] event_code, [5:3] pending_code,
                                          // [6] sampling_active
);

    logic                 r_in_vld;
    bclpc_pkg::t_item     r_in;
    logic                 r_out_vld;
    bclpc_pkg::t_result   r_out;
    bclpc_pkg::t_result   res;
    logic                 advance;

    assign advance         = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || advance;

    bclpc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (advance),
        .i_item      (r_in),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_vld <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in.func   <= i_s_axis_tuser;
            r_in.levels <= i_s_axis_tdata[2:0];
        end
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {1'b0, r_out.sampling_active, r_out.pending_code,
                              r_out.event_code};

    `BCLPC_ASSERT_NOW(a_read_clears, i_clk, i_rst_n, r_out_vld && (r_out.event_code != bclpc_pkg::EV_NONE), r_out.pending_code == bclpc_pkg::EV_NONE, "read returned an event but left one pending")
    `BCLPC_ASSERT_NOW(a_pending_legal, i_clk, i_rst_n, r_out_vld, r_out.pending_code <= bclpc_pkg::EV_B1_LONG, "pending code out of range")
    `BCLPC_ASSERT_NEXT(a_advance_fills, i_clk, i_rst_n, advance, r_out_vld, "processed word did not reach the result register")
    `BCLPC_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_vld && !advance, r_in_vld, "stalled input word was dropped")

endmodule
